### design/generational_slot_allocator_macros.svh
// ---------------------------------------------------------------------------
// Generational slot allocator assertion macros
// Concurrent check wrappers on clk with the asynchronous reset arst_n.
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define GSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/gsa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gsa_pkg
// Types, codes and field widths shared by the slot allocator.
// ---------------------------------------------------------------------------
package gsa_pkg;

	localparam int GSA_SLOTS    = 64;
	localparam int GSA_GEN_BITS = 16;

	// word field widths
	localparam int IDX_W    = 8;
	localparam int TAG_W    = 16;
	localparam int OUT_SLOT_W = 6;
	localparam int OUT_GEN_W  = 16;
	localparam int OUT_HW_W   = 7;

	localparam int S_DATA_W = 24; // slot_index + generation_tag
	localparam int S_USER_W = 1;  // operation
	localparam int M_DATA_W = 32; // slot_number + slot_generation + high_water, padded
	localparam int M_USER_W = 2;  // status

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} gsa_op_t;

	typedef enum logic [1:0] {
		STAT_ALLOCATED = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_RELEASED  = 2'd2,
		STAT_STALE     = 2'd3
	} gsa_status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} gsa_state_t;

endpackage
`default_nettype wire

### design/gsa_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gsa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module gsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### design/generational_slot_allocator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// generational_slot_allocator
// Slot table with active bits and per-slot generation counters.
// ---------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_ group. s_tuser carries the operation
//   (allocate or release); s_tdata carries the slot to release and the
//   generation the releaser holds. Allocate takes the lowest free slot and
//   bumps its generation; release frees a slot whose generation matches.
//   Result words leave on the m_ group: m_tuser holds the status, m_tdata
//   the slot, its generation and the high-water mark.
//   Each word is handled in a read step and then an execute step. The read
//   step reads the generation memory (address from the lowest-free encoder
//   or the request), the execute step modifies and writes it back; the next
//   word is not accepted until that write is done, so no forwarding is
//   needed.
//   The result waits in an output register; when the receiver stalls, hold
//   the result and drop s_tready until the register is taken (a new word is
//   accepted in the same cycle the old result leaves).
//   Reset clears every active bit, the high-water mark and a written bit
//   per slot; a slot never written reads as generation zero, so there is no
//   clearing pass and the block is ready in the first cycle after reset.
// ---------------------------------------------------------------------------
module generational_slot_allocator #(
	parameter int SLOTS    = gsa_pkg::GSA_SLOTS,
	parameter int GEN_BITS = gsa_pkg::GSA_GEN_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// slave side
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [gsa_pkg::S_DATA_W-1:0]  s_tdata,  // [7:0] slot_index, [23:8] generation_tag
	input  wire logic [gsa_pkg::S_USER_W-1:0]  s_tuser,  // [0] operation
	// master side
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [gsa_pkg::M_DATA_W-1:0]  m_tdata,  // [5:0] slot_number, [21:6] slot_generation,
	                                                     // [28:22] high_water, [31:29] zero
	output logic      [gsa_pkg::M_USER_W-1:0]  m_tuser   // [1:0] status
);

	import gsa_pkg::*;

	`include "generational_slot_allocator_macros.svh"

	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int HW_W     = $clog2(SLOTS + 1);
	localparam int CMP_W    = (GEN_BITS > TAG_W) ? GEN_BITS : TAG_W;
	localparam int SLOT_PAD = (SLOT_W > OUT_SLOT_W) ? SLOT_W : OUT_SLOT_W;
	localparam int HW_PAD   = (HW_W > OUT_HW_W) ? HW_W : OUT_HW_W;

	// Control state
	gsa_state_t            state_q, state_nx;
	logic [SLOTS-1:0]      slot_active_q;
	logic [SLOTS-1:0]      slot_written_q;
	logic [HW_W-1:0]       hw_q;

	// Request captured at the read cycle
	gsa_op_t               op_s1;
	logic [TAG_W-1:0]      tag_s1;
	logic [SLOT_W-1:0]     addr_s1;
	logic                  in_range_s1;
	logic                  full_s1;
	logic                  written_s1;

	// Result register
	logic                  m_tvalid_q;
	logic [M_DATA_W-1:0]   m_tdata_q;
	logic [M_USER_W-1:0]   m_tuser_q;

	logic                  accept;
	logic                  exec_en;

	// Input word fields
	gsa_op_t               in_op;
	logic [IDX_W-1:0]      in_idx;
	logic [TAG_W-1:0]      in_tag;

	assign in_op  = gsa_op_t'(s_tuser[0]);
	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_tag = s_tdata[IDX_W +: TAG_W];

	// Lowest free slot
	logic [SLOT_W-1:0]     free_idx;
	logic                  any_free;

	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!slot_active_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign any_free = ~&slot_active_q;

	// Generation memory
	logic [SLOT_W-1:0]     raddr;
	logic [GEN_BITS-1:0]   ram_rdata;
	logic                  ram_we;
	logic [GEN_BITS-1:0]   gen_new;

	assign raddr = (in_op == OP_RELEASE) ? in_idx[SLOT_W-1:0] : free_idx;

	gsa_ram #(
		.WIDTH (GEN_BITS),
		.DEPTH (SLOTS)
	) u_gen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (gen_new),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_nx = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				state_nx = FSM_IDLE;
			end
			default: begin
				state_nx = FSM_IDLE;
			end
		endcase
	end

	// State outputs: take a word only when idle and the result register is
	// free or being emptied this cycle
	always_comb begin
		s_tready = 1'b0;
		exec_en  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_tready = !m_tvalid_q || m_tready;
			end
			FSM_EXEC: begin
				exec_en = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// Execute: modify the generation and build the result word
	logic [GEN_BITS-1:0]   gen_rd;
	logic                  gen_match;
	gsa_status_t           res_status;
	logic [SLOT_W-1:0]     res_slot;
	logic [GEN_BITS-1:0]   res_gen;
	logic                  do_alloc;
	logic                  do_release;
	logic                  raise_hw;
	logic [HW_W-1:0]       hw_next;

	assign gen_rd    = written_s1 ? ram_rdata : '0;
	assign gen_new   = gen_rd + GEN_BITS'(1);
	assign gen_match = (CMP_W'(gen_rd) == CMP_W'(tag_s1));
	assign do_alloc   = exec_en && (op_s1 == OP_ALLOC) && !full_s1;
	assign do_release = exec_en && (op_s1 == OP_RELEASE) && in_range_s1 && gen_match;
	assign ram_we    = do_alloc;
	assign raise_hw  = HW_W'(addr_s1) >= hw_q;
	assign hw_next   = (do_alloc && raise_hw) ? (HW_W'(addr_s1) + HW_W'(1)) : hw_q;

	always_comb begin
		res_status = STAT_STALE;
		res_slot   = '0;
		res_gen    = '0;
		if (op_s1 == OP_ALLOC) begin
			if (full_s1) begin
				res_status = STAT_FULL;
			end else begin
				res_status = STAT_ALLOCATED;
				res_slot   = addr_s1;
				res_gen    = gen_new;
			end
		end else if (in_range_s1 && gen_match) begin
			res_status = STAT_RELEASED;
			res_slot   = addr_s1;
			res_gen    = gen_rd;
		end
	end

	// Capture the request while the memory reads
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= in_op;
			tag_s1      <= in_tag;
			addr_s1     <= raddr;
			in_range_s1 <= ({1'b0, in_idx} < (IDX_W + 1)'(SLOTS));
			full_s1     <= !any_free;
			written_s1  <= slot_written_q[raddr];
		end
	end

	// Table state and FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= FSM_IDLE;
			slot_active_q  <= '0;
			slot_written_q <= '0;
			hw_q           <= '0;
		end else begin
			state_q <= state_nx;
			hw_q    <= hw_next;
			if (do_alloc) begin
				slot_active_q[addr_s1]  <= 1'b1;
				slot_written_q[addr_s1] <= 1'b1;
			end
			if (do_release) begin
				slot_active_q[addr_s1] <= 1'b0;
			end
		end
	end

	// Result register: load at execute, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			m_tuser_q <= res_status;
			m_tdata_q <= {3'b000,
				OUT_HW_W'(HW_PAD'(hw_next)),
				OUT_GEN_W'(CMP_W'(res_gen)),
				OUT_SLOT_W'(SLOT_PAD'(res_slot))};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Checks
	`GSA_ASSERT_NEXT(a_accept_exec, accept, state_q == FSM_EXEC,
		"accepted word did not move to execute")
	`GSA_ASSERT_NEXT(a_exec_result, exec_en, m_tvalid_q,
		"execute cycle left no result word")
	`GSA_ASSERT_NOW(a_hw_bound, 1'b1, hw_q <= HW_W'(SLOTS),
		"high-water mark beyond slot count")

endmodule
`default_nettype wire

### tb/generational_slot_allocator_tb.sv
// ---------------------------------------------------------------------------
// generational_slot_allocator_tb
// Self-checking bench for the slot allocator. Requests go in on the s_ group
// and each accepted word is run through a behavioural copy of the slot table
// (active bits, generations, high-water mark). The predicted result is queued
// and every result word leaving the m_ group is compared against the oldest
// entry, field by field. Directed tests cover the first allocation, every
// release path, repeated reuse of one slot and a full table; random traffic
// follows under several sender and receiver idling mixes.
// ---------------------------------------------------------------------------
module generational_slot_allocator_tb;

	import gsa_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_LIMIT  = 100000;
	localparam int SETTLE       = 8;
	localparam int REPORT_MAX   = 10;
	localparam int REUSE_ROUNDS = 40;

	typedef struct {
		gsa_status_t           status;
		logic [OUT_SLOT_W-1:0] slot;
		logic [OUT_GEN_W-1:0]  gen;
		logic [OUT_HW_W-1:0]   high_water;
	} slot_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;  // [7:0] slot_index, [23:8] generation_tag
	logic [S_USER_W-1:0] s_tuser = '0;  // [0] operation
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;       // [5:0] slot, [21:6] generation, [28:22] high water
	logic [M_USER_W-1:0] m_tuser;       // [1:0] status

	// Shadow copy of the slot table, advanced once per accepted request word.
	bit                 slot_busy [GSA_SLOTS];
	logic [TAG_W-1:0]   slot_gen  [GSA_SLOTS];
	logic [OUT_HW_W-1:0] high_mark;

	slot_result_t pending_results[$];
	int           fail_count;
	int           send_idle_pct;
	int           recv_stall_pct;

	generational_slot_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#50000000;
		$display("FAIL generational_slot_allocator");
		$finish;
	end

	task automatic flag_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("mismatch: %s", msg);
	endtask

	// Apply one request to the shadow table and return the word it must produce.
	function automatic slot_result_t apply_request(input gsa_op_t op,
			input logic [IDX_W-1:0] idx, input logic [TAG_W-1:0] tag);
		slot_result_t r;
		bit           found;
		r.status = STAT_FULL;
		r.slot   = '0;
		r.gen    = '0;
		found    = 1'b0;
		if (op == OP_ALLOC) begin
			for (int i = 0; i < GSA_SLOTS; i++) begin
				if (!found && !slot_busy[i]) begin
					found        = 1'b1;
					slot_gen[i]  = slot_gen[i] + 1'b1;  // wraps at the top
					slot_busy[i] = 1'b1;
					if (i >= high_mark)
						high_mark = OUT_HW_W'(i + 1);
					r.status = STAT_ALLOCATED;
					r.slot   = OUT_SLOT_W'(i);
					r.gen    = slot_gen[i];
				end
			end
		end else if (idx >= GSA_SLOTS) begin
			r.status = STAT_STALE;
		end else if (slot_gen[idx] != tag) begin
			r.status = STAT_STALE;
		end else begin
			// a matching release of an already free slot still reports released
			slot_busy[idx] = 1'b0;
			r.status = STAT_RELEASED;
			r.slot   = idx[OUT_SLOT_W-1:0];
			r.gen    = slot_gen[idx];
		end
		r.high_water = high_mark;
		return r;
	endfunction

	function automatic int free_slots();
		int n;
		n = 0;
		for (int i = 0; i < GSA_SLOTS; i++)
			if (!slot_busy[i])
				n++;
		return n;
	endfunction

	// Pick a random active slot, or -1 when the table is empty.
	function automatic int pick_busy_slot();
		int n;
		int k;
		n = GSA_SLOTS - free_slots();
		if (n == 0)
			return -1;
		k = $urandom_range(n - 1);
		for (int i = 0; i < GSA_SLOTS; i++) begin
			if (slot_busy[i]) begin
				if (k == 0)
					return i;
				k--;
			end
		end
		return -1;
	endfunction

	// Present one request word and hold it until taken. Valid is only lowered
	// while idling, so back-to-back words never see two updates in one step.
	task automatic send_word(input gsa_op_t op, input logic [IDX_W-1:0] idx,
			input logic [TAG_W-1:0] tag, output slot_result_t predicted);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {tag, idx};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_request(op, idx, tag);
		pending_results.push_back(predicted);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Receiver: stall at random according to the current mix.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result checker: compare each taken word with the oldest prediction.
	always @(posedge clk) begin : check_results
		slot_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				flag_failure($sformatf("result word with nothing pending (status %0d)",
					m_tuser));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status)
					flag_failure($sformatf("status expected %0d got %0d",
						want.status, m_tuser));
				if (m_tdata[5:0] != want.slot)
					flag_failure($sformatf("slot expected %0d got %0d",
						want.slot, m_tdata[5:0]));
				if (m_tdata[21:6] != want.gen)
					flag_failure($sformatf("generation expected %0d got %0d",
						want.gen, m_tdata[21:6]));
				if (m_tdata[28:22] != want.high_water)
					flag_failure($sformatf("high water expected %0d got %0d",
						want.high_water, m_tdata[28:22]));
				if (m_tdata[31:29] != 3'b000)
					flag_failure($sformatf("padding expected 0 got %0d",
						m_tdata[31:29]));
			end
		end
	end

	// Allocation from an empty table: slot 0 then slot 1, generation one each.
	task automatic test_first_allocation();
		slot_result_t got;
		send_word(OP_ALLOC, 8'hFF, 16'hFFFF, got);
		send_word(OP_ALLOC, 8'h00, 16'h0000, got);
	endtask

	// Every release path: match, repeat on a free slot, stale tag, out of
	// range and a never-used slot at generation zero.
	task automatic test_release_paths();
		slot_result_t got;
		send_word(OP_RELEASE, 8'd0, 16'd1, got);
		send_word(OP_RELEASE, 8'd0, 16'd1, got);
		send_word(OP_RELEASE, 8'd1, 16'd5, got);
		send_word(OP_RELEASE, 8'd1, 16'h8001, got);
		send_word(OP_RELEASE, 8'd64, 16'd0, got);
		send_word(OP_RELEASE, 8'd255, 16'hFFFF, got);
		send_word(OP_RELEASE, 8'd128, 16'd1, got);
		send_word(OP_RELEASE, 8'd63, 16'd0, got);
		send_word(OP_ALLOC, 8'hA5, 16'h5A5A, got);
	endtask

	// Allocate and release the lowest free slot over and over, so its
	// generation keeps advancing.
	task automatic test_slot_reuse();
		slot_result_t got;
		for (int n = 0; n < REUSE_ROUNDS; n++) begin
			send_word(OP_ALLOC, IDX_W'($urandom), TAG_W'($urandom), got);
			if (got.status == STAT_ALLOCATED)
				send_word(OP_RELEASE, {2'b00, got.slot}, got.gen, got);
		end
	endtask

	// Fill the table, ask twice more, free a middle slot and take it back, then free the last and first slots.
	task automatic test_table_full();
		slot_result_t got;
		while (free_slots() > 0)
			send_word(OP_ALLOC, IDX_W'($urandom), TAG_W'($urandom), got);
		send_word(OP_ALLOC, 8'h00, 16'h0000, got);
		send_word(OP_ALLOC, 8'hFF, 16'hFFFF, got);
		send_word(OP_RELEASE, 8'd37, slot_gen[37], got);
		send_word(OP_ALLOC, 8'd0, 16'd0, got);
		send_word(OP_RELEASE, 8'd63, slot_gen[63], got);
		send_word(OP_RELEASE, 8'd0, slot_gen[0], got);
	endtask

	// Mostly well-formed traffic: allocations and releases of held handles,
	// with a share of stale tags and arbitrary words as noise.
	task automatic test_random_traffic(input int items, input int alloc_pct);
		slot_result_t got;
		int           r;
		int           s;
		for (int n = 0; n < items; n++) begin
			r = $urandom_range(99);
			s = pick_busy_slot();
			if (r < 8) begin
				send_word(OP_RELEASE, IDX_W'($urandom), TAG_W'($urandom), got);
			end else if (r < 14 && s >= 0) begin
				send_word(OP_RELEASE, IDX_W'(s),
					slot_gen[s] ^ (TAG_W'(1) << $urandom_range(TAG_W - 1)), got);
			end else if ($urandom_range(99) < alloc_pct || s < 0) begin
				send_word(OP_ALLOC, IDX_W'($urandom), TAG_W'($urandom), got);
			end else begin
				send_word(OP_RELEASE, IDX_W'(s), slot_gen[s], got);
			end
		end
	endtask

	initial begin
		int waited;
		fail_count = 0;
		high_mark  = '0;
		for (int i = 0; i < GSA_SLOTS; i++) begin
			slot_busy[i] = 1'b0;
			slot_gen[i]  = '0;
		end
		set_idling(0, 0);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_allocation();
		test_release_paths();
		test_slot_reuse();
		test_table_full();

		set_idling(0, 0);
		test_random_traffic(235, 85);
		set_idling(81, 0);
		test_random_traffic(235, 45);
		set_idling(0, 81);
		test_random_traffic(235, 70);
		set_idling(16, 16);
		test_random_traffic(235, 35);

		// drop valid and let every outstanding result come home
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (pending_results.size() != 0)
			flag_failure($sformatf("%0d results never arrived", pending_results.size()));

		if (fail_count == 0) begin
			$display("PASS generational_slot_allocator");
		end else begin
			$display("FAIL generational_slot_allocator");
		end
		$finish;
	end

endmodule
